>>> src/vrs_pkg.sv
package vrs_pkg;

  // store geometry
  localparam int unsigned STORE_BYTES   = 256;
  localparam int unsigned MAX_REC_BYTES = 8;
  localparam int unsigned HDR_BYTES     = 4;

  localparam int unsigned ADDR_W = $clog2(STORE_BYTES);
  // top offset can equal the store size
  localparam int unsigned TOP_W  = ADDR_W + 1;
  // address sums that may run past the end of the store
  localparam int unsigned EXT_W  = TOP_W + 1;

  // field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned FREE_W = 9;

  // byte counter covers a whole record plus its header
  localparam int unsigned CNT_W  = $clog2(MAX_REC_BYTES + HDR_BYTES + 1);
  localparam int unsigned BIDX_W = (MAX_REC_BYTES > 1) ? $clog2(MAX_REC_BYTES) : 1;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned IN_TUSER_W  = CMD_W;
  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = CMD_W'(0),
    CMD_POP    = CMD_W'(1),
    CMD_PEEK   = CMD_W'(2),
    CMD_CLEAR  = CMD_W'(3),
    CMD_STATUS = CMD_W'(4)
  } cmd_e;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              empty;
    logic              fits;
    logic [FREE_W-1:0] free;
  } res_t;

endpackage

>>> src/vrs_ram.sv
module vrs_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/vrs_ctrl.sv
module vrs_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [vrs_pkg::CMD_W-1:0]    cmd_i,
  input  logic [vrs_pkg::DATA_W-1:0]   data_i,
  input  logic [vrs_pkg::LEN_W-1:0]    len_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output vrs_pkg::res_t                res_o,
  output logic                         ram_we_o,
  output logic [vrs_pkg::ADDR_W-1:0]   ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic                         ram_re_o,
  output logic [vrs_pkg::ADDR_W-1:0]   ram_raddr_o,
  input  logic [7:0]                   ram_rdata_i
);

  import vrs_pkg::*;

  localparam int unsigned RDATA_W = 8 * MAX_REC_BYTES;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR,
    ST_RD_HDR,
    ST_CALC,
    ST_RD_DATA,
    ST_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [TOP_W-1:0]    top_q, top_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                rd_pend_q, rd_pend_d;

  cmd_e                cmd_q, cmd_d;
  logic [RDATA_W-1:0]  data_q, data_d;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                fits_q, fits_d;
  logic                ok_q, ok_d;
  logic [RDATA_W-1:0]  out_q, out_d;
  logic [LEN_W-1:0]    olen_q, olen_d;
  logic [ADDR_W-1:0]   wbase_q, wbase_d;
  logic [7:0]          hdr0_q, hdr0_d;
  logic                hdr_big_q, hdr_big_d;
  logic [CNT_W-1:0]    rd_idx_q, rd_idx_d;
  logic                rd_zero_q, rd_zero_d;

  logic [LEN_W-1:0]    len_sat;
  logic [TOP_W-1:0]    need;
  logic                fits_now;
  logic [7:0]          rd_byte;
  logic [EXT_W-1:0]    rd_off;
  logic [EXT_W-1:0]    rd_ext;
  logic                rd_in_range;
  logic                issue;
  logic [LEN_W-1:0]    stored;
  logic [EXT_W-1:0]    pop_top;
  logic [BIDX_W-1:0]   widx;
  logic [CNT_W-1:0]    wr_last;

  always_comb begin
    len_sat  = (len_i > LEN_W'(MAX_REC_BYTES)) ? LEN_W'(MAX_REC_BYTES) : len_i;
    need     = TOP_W'(len_sat) + TOP_W'(HDR_BYTES);
    fits_now = top_q >= need;

    // bytes beyond the end of the store read as zero
    rd_byte  = rd_zero_q ? 8'h00 : ram_rdata_i;

    if (state_q == ST_RD_DATA) begin
      rd_off = EXT_W'(HDR_BYTES) + EXT_W'(cnt_q);
    end else begin
      rd_off = EXT_W'(cnt_q);
    end
    rd_ext      = EXT_W'(top_q) + rd_off;
    rd_in_range = rd_ext < EXT_W'(STORE_BYTES);
    issue       = ((state_q == ST_RD_HDR) && (cnt_q < CNT_W'(HDR_BYTES))) ||
                  ((state_q == ST_RD_DATA) && (cnt_q < CNT_W'(olen_q)));

    // corrupt headers saturate to the largest record
    stored  = (hdr_big_q || (hdr0_q > 8'(MAX_REC_BYTES))) ? LEN_W'(MAX_REC_BYTES)
                                                           : LEN_W'(hdr0_q);
    pop_top = EXT_W'(top_q) + EXT_W'(HDR_BYTES) + EXT_W'(stored);

    widx    = BIDX_W'(cnt_q - CNT_W'(HDR_BYTES));
    wr_last = CNT_W'(len_q) + CNT_W'(HDR_BYTES - 1);
  end

  // write port: header first at the new top, then the data bytes above it
  always_comb begin
    ram_we_o    = state_q == ST_WR;
    ram_waddr_o = wbase_q + ADDR_W'(cnt_q);
    if (cnt_q < CNT_W'(HDR_BYTES)) begin
      ram_wdata_o = (cnt_q == '0) ? 8'(len_q) : 8'h00;
    end else begin
      ram_wdata_o = data_q[8*widx +: 8];
    end
    ram_re_o    = issue;
    ram_raddr_o = rd_ext[ADDR_W-1:0];
  end

  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    cnt_d     = cnt_q;
    cmd_d     = cmd_q;
    data_d    = data_q;
    len_d     = len_q;
    fits_d    = fits_q;
    ok_d      = ok_q;
    out_d     = out_q;
    olen_d    = olen_q;
    wbase_d   = wbase_q;
    hdr0_d    = hdr0_q;
    hdr_big_d = hdr_big_q;
    rd_pend_d = issue;
    rd_idx_d  = cnt_q;
    rd_zero_d = !rd_in_range;

    // read data lands in the cycle after the address went out
    if (rd_pend_q) begin
      if (state_q == ST_RD_HDR) begin
        if (rd_idx_q == '0) begin
          hdr0_d = rd_byte;
        end else if (rd_byte != 8'h00) begin
          hdr_big_d = 1'b1;
        end
      end else begin
        out_d[8*rd_idx_q[BIDX_W-1:0] +: 8] = rd_byte;
      end
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d     = cmd_e'(cmd_i);
          data_d    = data_i[RDATA_W-1:0];
          len_d     = len_sat;
          fits_d    = fits_now;
          out_d     = '0;
          olen_d    = '0;
          cnt_d     = '0;
          hdr0_d    = 8'h00;
          hdr_big_d = 1'b0;
          wbase_d   = ADDR_W'(top_q - need);
          ok_d      = 1'b0;
          state_d   = ST_RESP;
          case (cmd_i)
            CMD_PUSH: begin
              if (fits_now) begin
                ok_d    = 1'b1;
                state_d = ST_WR;
              end
            end
            CMD_POP, CMD_PEEK: begin
              if (top_q < TOP_W'(STORE_BYTES)) begin
                ok_d    = 1'b1;
                state_d = ST_RD_HDR;
              end
            end
            CMD_CLEAR: begin
              ok_d  = 1'b1;
              top_d = TOP_W'(STORE_BYTES);
            end
            CMD_STATUS: begin
              ok_d = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
        end
      end
      ST_WR: begin
        if (cnt_q == wr_last) begin
          top_d   = TOP_W'(wbase_q);
          state_d = ST_RESP;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_RD_HDR: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!rd_pend_q) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        olen_d  = (len_q < stored) ? len_q : stored;
        cnt_d   = '0;
        state_d = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end else if (!rd_pend_q) begin
          // the top moves only once the data bytes have been read
          if (cmd_q == CMD_POP) begin
            top_d = (pop_top > EXT_W'(STORE_BYTES)) ? TOP_W'(STORE_BYTES)
                                                    : TOP_W'(pop_top);
          end
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      top_q     <= TOP_W'(STORE_BYTES);
      cnt_q     <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      top_q     <= top_d;
      cnt_q     <= cnt_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    data_q    <= data_d;
    len_q     <= len_d;
    fits_q    <= fits_d;
    ok_q      <= ok_d;
    out_q     <= out_d;
    olen_q    <= olen_d;
    wbase_q   <= wbase_d;
    hdr0_q    <= hdr0_d;
    hdr_big_q <= hdr_big_d;
    rd_idx_q  <= rd_idx_d;
    rd_zero_q <= rd_zero_d;
  end

  assign in_ready_o  = state_q == ST_IDLE;
  assign res_valid_o = state_q == ST_RESP;

  always_comb begin
    res_o       = '0;
    res_o.ok    = ok_q;
    res_o.data  = DATA_W'(out_q);
    res_o.len   = olen_q;
    res_o.empty = top_q >= TOP_W'(STORE_BYTES);
    res_o.fits  = fits_q;
    res_o.free  = FREE_W'(top_q);
  end

  a_top_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= TOP_W'(STORE_BYTES))
    else $error("top offset beyond store");

  a_port_conflict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we_o && ram_re_o))
    else $error("read and write issued together");

  a_idle_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_pend_q)
    else $error("read data in flight while idle");

  a_read_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == ST_RD_HDR || state_q == ST_RD_DATA))
    else $error("read data returned outside a read phase");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (olen_q <= LEN_W'(MAX_REC_BYTES)))
    else $error("returned length above record limit");

endmodule

>>> src/variable_record_stack.sv
// Record stack: a 256-byte store that grows downward and holds records of up
// to eight bytes, each stored as its data bytes with a four-byte length
// header below them. Commands arrive on the slave stream (tuser carries the
// command: push, pop, peek, clear, status) and every command yields exactly
// one result transfer on the master stream. Lengths above eight are treated
// as eight. Pop and peek return the smaller of the requested and stored
// length, the unused high bytes zero. One command is processed at a time;
// the state lives in a single byte-wide memory with a registered read. A
// push writes its header, then its data bytes, one byte written per cycle; a
// pop or peek reads the header, then the returned data bytes, one byte per
// cycle; clear, status and refused commands touch no memory. The result sits
// in an output register, so the next command is taken while the previous
// result still waits. Bytes never written are undefined; no clearing pass
// runs after reset.
module variable_record_stack (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // slave side: command transfers
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // record_data[63:0], record_length[67:64], zero[71:68]
  input  logic [vrs_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd[2:0]
  input  logic [vrs_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  // master side: result transfers
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // ok[0], out_data[64:1], out_length[68:65], is_empty[69],
  // length_fits[70], free_bytes[79:71]
  output logic [vrs_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  import vrs_pkg::*;

  logic               res_valid;
  logic               res_ready;
  res_t               res;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;

  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // sequencer: decodes a command and walks the store one byte per cycle
  vrs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i[DATA_W-1:0]),
    .len_i       (s_axis_tdata_i[DATA_W +: LEN_W]),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  // byte store, one write and one registered read port
  vrs_ram #(
    .DEPTH (STORE_BYTES),
    .WIDTH (8)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register: takes a result whenever it is empty or being drained
  assign res_ready = !m_valid_q || m_axis_tready_i;

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    if (res_valid && res_ready) begin
      m_valid_d = 1'b1;
      m_data_d  = OUT_TDATA_W'({res.free, res.fits, res.empty, res.len, res.data, res.ok});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  import vrs_pkg::*;

  // command codes outside the defined set, expected to be ignored
  localparam logic [CMD_W-1:0] CMD_RSVD5 = CMD_W'(5);
  localparam logic [CMD_W-1:0] CMD_RSVD6 = CMD_W'(6);
  localparam logic [CMD_W-1:0] CMD_RSVD7 = CMD_W'(7);

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic [IN_TUSER_W-1:0]  s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  variable_record_stack u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // shadow copy of the store and its top
  logic [7:0]  shadow_mem [STORE_BYTES];
  int unsigned shadow_top;

  res_t awaited_results [$];

  // idling odds, in percent
  int unsigned src_idle;
  int unsigned sink_idle;

  int err_cnt;
  int cmd_cnt;
  int res_cnt;
  int refused_pushes;
  int full_reads;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // generous watchdog
  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

  // expected outcome of one command; updates the shadow store
  function automatic res_t predict_stack_result(logic [CMD_W-1:0] op,
                                                logic [DATA_W-1:0] data,
                                                logic [LEN_W-1:0] req_len);
    int unsigned n;
    int unsigned stored;
    int unsigned base;
    int unsigned nt;
    int unsigned addr;
    res_t r;
    r = '0;
    n = (req_len > MAX_REC_BYTES) ? MAX_REC_BYTES : req_len;
    r.fits = (shadow_top >= n + HDR_BYTES);
    case (op)
      CMD_PUSH: begin
        if (r.fits) begin
          shadow_top -= n;
          for (int i = 0; i < n; i++) shadow_mem[shadow_top + i] = data[8*i +: 8];
          shadow_top -= HDR_BYTES;
          // little-endian length header, only the low byte can be non-zero
          for (int i = 0; i < HDR_BYTES; i++)
            shadow_mem[shadow_top + i] = (i == 0) ? 8'(n) : 8'h00;
          r.ok = 1'b1;
        end
      end
      CMD_POP, CMD_PEEK: begin
        if (shadow_top < STORE_BYTES) begin
          stored = 0;
          for (int i = 0; i < HDR_BYTES && i < 4; i++) begin
            addr = shadow_top + i;
            if (addr < STORE_BYTES) stored |= int'(shadow_mem[addr]) << (8 * i);
          end
          if (stored > MAX_REC_BYTES) stored = MAX_REC_BYTES;
          base = shadow_top + HDR_BYTES;
          r.len = LEN_W'((n < stored) ? n : stored);
          for (int i = 0; i < r.len; i++) begin
            addr = base + i;
            if (addr < STORE_BYTES) r.data[8*i +: 8] = shadow_mem[addr];
          end
          if (op == CMD_POP) begin
            nt = base + stored;
            shadow_top = (nt > STORE_BYTES) ? STORE_BYTES : nt;
          end
          r.ok = 1'b1;
        end
      end
      CMD_CLEAR: begin
        shadow_top = STORE_BYTES;
        r.ok = 1'b1;
      end
      CMD_STATUS: r.ok = 1'b1;
      default: ;
    endcase
    r.empty = (shadow_top >= STORE_BYTES);
    r.free  = FREE_W'(shadow_top);
    return r;
  endfunction

  // one command transfer; entered and left at a falling edge
  task automatic send_command(logic [CMD_W-1:0] op, logic [DATA_W-1:0] data,
                              logic [LEN_W-1:0] len);
    res_t r;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid_i = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {4'b0, len, data};
    s_axis_tvalid_i = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = predict_stack_result(op, data, len);
    if (op == CMD_PUSH && !r.ok) refused_pushes++;
    if ((op == CMD_POP || op == CMD_PEEK) && r.len != 0) full_reads++;
    awaited_results.push_back(r);
    cmd_cnt++;
    @(negedge clk_i);
  endtask

  // hold the sender off until every result is back
  task automatic wait_drained();
    s_axis_tvalid_i = 1'b0;
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  // mostly legal lengths, now and then an oversized one that saturates
  function automatic logic [LEN_W-1:0] rand_len();
    return ($urandom_range(99) < 85) ? LEN_W'($urandom_range(MAX_REC_BYTES))
                                     : LEN_W'($urandom_range(15, MAX_REC_BYTES + 1));
  endfunction

  // receiver back-pressure
  always @(negedge clk_i) begin
    m_axis_tready_i = ($urandom_range(99) >= sink_idle);
  end

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // result checking on every accepted transfer
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with no command awaiting it");
        err_cnt++;
      end else begin
        check_field("ok",          awaited_results[0].ok,    m_axis_tdata_o[0]);
        check_field("out_data",    awaited_results[0].data,  m_axis_tdata_o[64:1]);
        check_field("out_length",  awaited_results[0].len,   m_axis_tdata_o[68:65]);
        check_field("is_empty",    awaited_results[0].empty, m_axis_tdata_o[69]);
        check_field("length_fits", awaited_results[0].fits,  m_axis_tdata_o[70]);
        check_field("free_bytes",  awaited_results[0].free,  m_axis_tdata_o[79:71]);
        void'(awaited_results.pop_front());
        res_cnt++;
      end
    end
  end

  // edge cases: empty reads, zero-length and oversized records, unknown codes
  task automatic test_directed();
    send_command(CMD_POP,    '0, 4'd8);
    send_command(CMD_PEEK,   '0, 4'd0);
    send_command(CMD_STATUS, '0, 4'd0);
    send_command(CMD_STATUS, '1, 4'd15);
    send_command(CMD_PUSH,   rand_data(), 4'd0);
    send_command(CMD_PEEK,   '0, 4'd8);
    send_command(CMD_POP,    '0, 4'd4);
    send_command(CMD_PUSH,   '1, 4'd8);
    send_command(CMD_PUSH,   64'h0123_4567_89ab_cdef, 4'd15);
    send_command(CMD_PEEK,   '0, 4'd3);
    send_command(CMD_PEEK,   '0, 4'd15);
    send_command(CMD_POP,    '0, 4'd0);
    send_command(CMD_POP,    '0, 4'd8);
    send_command(CMD_POP,    '0, 4'd8);
    send_command(CMD_PUSH,   64'hA5, 4'd1);
    send_command(CMD_RSVD5,  '1, 4'd8);
    send_command(CMD_RSVD6,  '0, 4'd0);
    send_command(CMD_RSVD7,  '1, 4'd15);
    send_command(CMD_CLEAR,  '0, 4'd0);
    send_command(CMD_PEEK,   '0, 4'd8);
    send_command(CMD_PUSH,   rand_data(), 4'd3);
    send_command(CMD_STATUS, '0, 4'd8);
    send_command(CMD_POP,    '0, 4'd2);
    send_command(CMD_POP,    '0, 4'd15);
  endtask

  // fill the store to the last byte, hit the full case, then drain it
  task automatic test_fill_drain();
    send_command(CMD_CLEAR, '0, 4'd0);
    while (shadow_top >= MAX_REC_BYTES + HDR_BYTES)
      send_command(CMD_PUSH, rand_data(), LEN_W'(MAX_REC_BYTES));
    send_command(CMD_STATUS, '0, 4'd15);
    send_command(CMD_PUSH,   rand_data(), 4'd15);
    // a bare header still fits, after which nothing does
    while (shadow_top >= HDR_BYTES) send_command(CMD_PUSH, rand_data(), 4'd0);
    send_command(CMD_PUSH,   rand_data(), 4'd0);
    send_command(CMD_STATUS, '0, 4'd0);
    while (shadow_top < STORE_BYTES) begin
      if ($urandom_range(3) == 0) send_command(CMD_PEEK, '0, rand_len());
      send_command(CMD_POP, '0, rand_len());
    end
    send_command(CMD_POP, '0, 4'd8);
  endtask

  // random command mix, alternating between filling and draining spells
  task automatic test_random(int n_cmds);
    int unsigned roll;
    bit          filling;
    for (int i = 0; i < n_cmds; i++) begin
      filling = ((i / 40) % 2) == 0;
      roll    = $urandom_range(99);
      if (i == n_cmds / 2) wait_drained();
      if (roll < (filling ? 55 : 25))
        send_command(CMD_PUSH, rand_data(), rand_len());
      else if (roll < 72)
        send_command(CMD_POP, rand_data(), rand_len());
      else if (roll < 84)
        send_command(CMD_PEEK, rand_data(), rand_len());
      else if (roll < 94)
        send_command(CMD_STATUS, rand_data(), rand_len());
      else if (roll < 96)
        send_command(CMD_CLEAR, rand_data(), rand_len());
      else
        send_command(CMD_W'($urandom_range(7, 5)), rand_data(), rand_len());
    end
  endtask

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) shadow_mem[i] = 8'h00;
    shadow_top      = STORE_BYTES;
    err_cnt         = 0;
    cmd_cnt         = 0;
    res_cnt         = 0;
    refused_pushes  = 0;
    full_reads      = 0;
    src_idle        = 9;
    sink_idle       = 70;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    m_axis_tready_i = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_fill_drain();
    test_random(215);
    wait_drained();

    src_idle  = 70;
    sink_idle = 9;
    test_random(215);
    wait_drained();

    src_idle  = 0;
    sink_idle = 0;
    test_random(215);

    wait_drained();
    repeat (40) @(negedge clk_i);

    $display("ran %0d commands, %0d results checked", cmd_cnt, res_cnt);
    $display("refused pushes: %0d, pops and peeks returning data: %0d",
             refused_pushes, full_reads);
    if (err_cnt == 0 && awaited_results.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
